FILE: rtl/bankers_safe_allocator_top_defines.svh
// assertion macros for the bankers safe allocator
// uses the clk and rst_n names of the module that includes it
`ifndef BANKERS_SAFE_ALLOCATOR_TOP_DEFINES_SVH
`define BANKERS_SAFE_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication
`define BSA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/bsa_pkg.sv
// bankers safe allocator package: request and result types, codes,
// controller command and status structs; no dependencies
package bsa_pkg;

  localparam logic [2:0] OP_LOAD_AVAIL = 3'd0;
  localparam logic [2:0] OP_LOAD_MAX   = 3'd1;
  localparam logic [2:0] OP_LOAD_ALLOC = 3'd2;
  localparam logic [2:0] OP_REQUEST    = 3'd3;
  localparam logic [2:0] OP_CHECK      = 3'd4;

  localparam logic [2:0] ST_ACCEPTED      = 3'd0;
  localparam logic [2:0] ST_GRANTED       = 3'd1;
  localparam logic [2:0] ST_DENIED_LIMIT  = 3'd2;
  localparam logic [2:0] ST_DENIED_UNSAFE = 3'd3;
  localparam logic [2:0] ST_CHECKED       = 3'd4;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_THREADS   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESOURCES = 1'd1;

  typedef struct packed {
    logic [2:0]  operation;
    logic [3:0]  thread;
    logic [2:0]  resource;
    logic [15:0] amount;
    logic        last;
  } bsa_req_t;

  typedef struct packed {
    logic [2:0] status;
    logic       safe;
  } bsa_rsp_t;

  typedef struct packed {
    logic       capture;
    logic       load_avail;
    logic       load_max;
    logic       rd_req;
    logic       load_alloc_wr;
    logic       pend_write;
    logic       pend_clear;
    logic       r_clear;
    logic       r_step;
    logic       rd_pend;
    logic       rd_scan;
    logic       scan_init;
    logic       t_step;
    logic       pass_restart;
    logic       finish_thread;
    logic       work_add;
    logic       commit_wr;
    logic       respond;
    logic [2:0] status;
    logic       safe;
  } bsa_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       tr_ok;
    logic       last;
    logic       pend_t_ok;
    logic       r_end;
    logic       t_end;
    logic       fin;
    logic       progress;
    logic       all_done;
    logic       deny;
    logic       no_fit;
    logic       eval;
  } bsa_sts_t;

endpackage

FILE: rtl/bsa_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module bsa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/bsa_ctrl.sv
// bankers safe allocator controller: sequences loads, request evaluation,
// safety scan and commit; depends on bsa_pkg
module bsa_ctrl
  import bsa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  bsa_sts_t sts,
  output bsa_cmd_t cmd,
  output logic     busy
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DEC     = 4'd1;
  localparam logic [3:0] S_ALLOC   = 4'd2;
  localparam logic [3:0] S_EV_RD   = 4'd3;
  localparam logic [3:0] S_EV_CMP  = 4'd4;
  localparam logic [3:0] S_INIT    = 4'd5;
  localparam logic [3:0] S_THREAD  = 4'd6;
  localparam logic [3:0] S_CHK_RD  = 4'd7;
  localparam logic [3:0] S_CHK_CMP = 4'd8;
  localparam logic [3:0] S_ADD_RD  = 4'd9;
  localparam logic [3:0] S_ADD_ACC = 4'd10;
  localparam logic [3:0] S_COM_RD  = 4'd11;
  localparam logic [3:0] S_COM_WR  = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic       scan_end, scan_safe;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    scan_end  = 1'b0;
    scan_safe = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DEC;
        end
      end
      S_DEC: begin
        unique case (sts.op)
          OP_LOAD_AVAIL: begin
            cmd.load_avail = 1'b1;
            cmd.respond    = 1'b1;
            state_nxt      = S_IDLE;
          end
          OP_LOAD_MAX: begin
            cmd.load_max = 1'b1;
            cmd.respond  = 1'b1;
            state_nxt    = S_IDLE;
          end
          OP_LOAD_ALLOC: begin
            if (sts.tr_ok) begin
              cmd.rd_req = 1'b1;
              state_nxt  = S_ALLOC;
            end else begin
              cmd.respond = 1'b1;
              state_nxt   = S_IDLE;
            end
          end
          OP_REQUEST: begin
            cmd.pend_write = 1'b1;
            cmd.r_clear    = 1'b1;
            if (sts.last) begin
              state_nxt = S_EV_RD;
            end else begin
              cmd.respond = 1'b1;
              state_nxt   = S_IDLE;
            end
          end
          OP_CHECK: begin
            state_nxt = S_INIT;
          end
          default: begin
            cmd.respond = 1'b1;
            state_nxt   = S_IDLE;
          end
        endcase
      end
      S_ALLOC: begin
        cmd.load_alloc_wr = 1'b1;
        cmd.respond       = 1'b1;
        state_nxt         = S_IDLE;
      end
      S_EV_RD: begin
        if (!sts.pend_t_ok) begin
          cmd.respond    = 1'b1;
          cmd.status     = ST_DENIED_LIMIT;
          cmd.pend_clear = 1'b1;
          state_nxt      = S_IDLE;
        end else if (sts.r_end) begin
          state_nxt = S_INIT;
        end else begin
          cmd.rd_pend = 1'b1;
          state_nxt   = S_EV_CMP;
        end
      end
      S_EV_CMP: begin
        if (sts.deny) begin
          cmd.respond    = 1'b1;
          cmd.status     = ST_DENIED_LIMIT;
          cmd.pend_clear = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          cmd.r_step = 1'b1;
          state_nxt  = S_EV_RD;
        end
      end
      S_INIT: begin
        cmd.scan_init = 1'b1;
        state_nxt     = S_THREAD;
      end
      S_THREAD: begin
        if (sts.all_done) begin
          scan_end  = 1'b1;
          scan_safe = 1'b1;
        end else if (sts.t_end) begin
          if (sts.progress) begin
            cmd.pass_restart = 1'b1;
          end else begin
            scan_end = 1'b1;
          end
        end else if (sts.fin) begin
          cmd.t_step = 1'b1;
        end else begin
          cmd.r_clear = 1'b1;
          state_nxt   = S_CHK_RD;
        end
      end
      S_CHK_RD: begin
        cmd.r_clear = sts.r_end;
        cmd.rd_scan = !sts.r_end;
        state_nxt   = sts.r_end ? S_ADD_RD : S_CHK_CMP;
      end
      S_CHK_CMP: begin
        if (sts.no_fit) begin
          cmd.t_step = 1'b1;
          state_nxt  = S_THREAD;
        end else begin
          cmd.r_step = 1'b1;
          state_nxt  = S_CHK_RD;
        end
      end
      S_ADD_RD: begin
        if (sts.r_end) begin
          cmd.finish_thread = 1'b1;
          state_nxt         = S_THREAD;
        end else begin
          cmd.rd_scan = 1'b1;
          state_nxt   = S_ADD_ACC;
        end
      end
      S_ADD_ACC: begin
        cmd.work_add = 1'b1;
        cmd.r_step   = 1'b1;
        state_nxt    = S_ADD_RD;
      end
      S_COM_RD: begin
        if (sts.r_end) begin
          cmd.respond    = 1'b1;
          cmd.status     = ST_GRANTED;
          cmd.safe       = 1'b1;
          cmd.pend_clear = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          cmd.rd_pend = 1'b1;
          state_nxt   = S_COM_WR;
        end
      end
      S_COM_WR: begin
        cmd.commit_wr = 1'b1;
        cmd.r_step    = 1'b1;
        state_nxt     = S_COM_RD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (scan_end) begin
      if (!sts.eval) begin
        cmd.respond = 1'b1;
        cmd.status  = ST_CHECKED;
        cmd.safe    = scan_safe;
        state_nxt   = S_IDLE;
      end else if (scan_safe) begin
        cmd.r_clear = 1'b1;
        state_nxt   = S_COM_RD;
      end else begin
        cmd.respond    = 1'b1;
        cmd.status     = ST_DENIED_UNSAFE;
        cmd.pend_clear = 1'b1;
        state_nxt      = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

FILE: rtl/bsa_datapath.sv
// bankers safe allocator datapath: counts, need and held memories,
// work pool, pending request and result register; depends on bsa_pkg, bsa_ram
module bsa_datapath
  import bsa_pkg::*;
#(
  parameter int THREAD_SLOTS   = 16,
  parameter int RESOURCE_TYPES = 8,
  parameter int COUNT_BITS     = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bsa_req_t              in_req,
  input  logic [CFG_DATA_W-1:0] cfg_threads,
  input  logic [3:0]            cfg_resources,
  input  bsa_cmd_t              cmd,
  output bsa_sts_t              sts,
  output logic                  out_valid,
  output bsa_rsp_t              out_rsp
);

  localparam int CW    = COUNT_BITS;
  localparam int NW    = CW + 1;
  localparam int WW    = CW + 5;
  localparam int DEPTH = THREAD_SLOTS * RESOURCE_TYPES;
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = $clog2(THREAD_SLOTS + 1);
  localparam int TIW   = $clog2(THREAD_SLOTS);
  localparam int RW    = $clog2(RESOURCE_TYPES + 1);
  localparam int RIW   = (RESOURCE_TYPES > 1) ? $clog2(RESOURCE_TYPES) : 1;
  localparam logic [CW-1:0] CNT_MAX  = '1;
  localparam logic [WW-1:0] WORK_MAX = '1;
  localparam logic [NW-1:0] NEED_MAX = {1'b0, {CW{1'b1}}};
  localparam logic [NW-1:0] NEED_MIN = {1'b1, {CW{1'b0}}};

  bsa_req_t         req_r;
  logic [CW-1:0]    avail_r [RESOURCE_TYPES];
  logic [CW-1:0]    pend_r  [RESOURCE_TYPES];
  logic [3:0]       pend_t_r;
  logic [WW-1:0]    work_r  [RESOURCE_TYPES];
  logic [THREAD_SLOTS-1:0] fin_r;
  logic [DEPTH-1:0] need_vld_r, held_vld_r;
  logic             need_vq_r, held_vq_r;
  logic [RW-1:0]    r_idx_r;
  logic [TW-1:0]    t_idx_r, done_r;
  logic             progress_r, eval_r;
  logic             out_valid_r;
  bsa_rsp_t         out_rsp_r;

  logic [TW-1:0]    nt;
  logic [RW-1:0]    nr;
  logic [32:0]      amt_ext;
  logic [CW-1:0]    amt;
  logic             t_ok, r_ok, tr_ok, pend_t_ok, t_match, use_p;
  logic [RIW-1:0]   ri, rq;
  logic [AW-1:0]    k_req, k_pend, k_scan, raddr, waddr;
  logic [NW-1:0]    need_rdata, need_rd, need_wdata;
  logic [CW-1:0]    held_rdata, held_rd, held_eff, held_wdata;
  logic             need_we, held_we;
  logic [CW-1:0]    p_cur, avail_cur;
  logic [WW-1:0]    work_cur;
  logic signed [CW+1:0] p_s, need_s, need_eff, need_dec;
  logic [CW:0]      held_sum;
  logic [WW:0]      work_sum;
  logic [NW-1:0]    need_sat;

  assign nt = (32'(cfg_threads) > 32'(THREAD_SLOTS)) ? TW'(THREAD_SLOTS) : TW'(cfg_threads);
  assign nr = (32'(cfg_resources) > 32'(RESOURCE_TYPES)) ? RW'(RESOURCE_TYPES)
                                                         : RW'(cfg_resources);

  assign amt_ext   = 33'(req_r.amount);
  assign amt       = (amt_ext > 33'(CNT_MAX)) ? CNT_MAX : CW'(amt_ext);
  assign t_ok      = 32'(req_r.thread) < 32'(THREAD_SLOTS);
  assign r_ok      = 32'(req_r.resource) < 32'(RESOURCE_TYPES);
  assign tr_ok     = t_ok && r_ok;
  assign pend_t_ok = 32'(pend_t_r) < 32'(THREAD_SLOTS);
  assign t_match   = 32'(t_idx_r) == 32'(pend_t_r);
  assign use_p     = eval_r && (cmd.commit_wr || t_match);

  assign ri = r_idx_r[RIW-1:0];
  assign rq = RIW'(req_r.resource);

  assign k_req  = AW'(req_r.thread) * AW'(RESOURCE_TYPES) + AW'(rq);
  assign k_pend = AW'(pend_t_r) * AW'(RESOURCE_TYPES) + AW'(ri);
  assign k_scan = AW'(t_idx_r[TIW-1:0]) * AW'(RESOURCE_TYPES) + AW'(ri);

  always_comb begin
    priority if (cmd.rd_req) begin
      raddr = k_req;
    end else if (cmd.rd_pend) begin
      raddr = k_pend;
    end else begin
      raddr = k_scan;
    end
  end

  assign need_rd   = need_vq_r ? need_rdata : '0;
  assign held_rd   = held_vq_r ? held_rdata : '0;
  assign p_cur     = pend_r[ri];
  assign avail_cur = avail_r[ri];
  assign work_cur  = work_r[ri];

  assign p_s      = $signed({2'b00, p_cur});
  assign need_s   = $signed({need_rd[NW-1], need_rd});
  assign need_eff = use_p ? (need_s - p_s) : need_s;
  assign need_dec = cmd.commit_wr ? (need_s - p_s) : (need_s - $signed({2'b00, amt}));

  always_comb begin
    if (need_dec[CW+1] == need_dec[CW]) begin
      need_sat = need_dec[NW-1:0];
    end else if (need_dec[CW+1]) begin
      need_sat = NEED_MIN;
    end else begin
      need_sat = NEED_MAX;
    end
  end

  assign held_sum = {1'b0, held_rd} + (use_p ? {1'b0, p_cur} : '0);
  assign held_eff = held_sum[CW] ? CNT_MAX : held_sum[CW-1:0];
  assign work_sum = {1'b0, work_cur} + (WW+1)'(held_eff);

  assign waddr      = cmd.commit_wr ? k_pend : k_req;
  assign need_we    = (cmd.load_max && tr_ok) || cmd.load_alloc_wr || cmd.commit_wr;
  assign held_we    = cmd.load_alloc_wr || cmd.commit_wr;
  assign need_wdata = cmd.load_max ? NW'(amt) : need_sat;
  assign held_wdata = cmd.commit_wr ? held_eff : amt;

  bsa_ram #(.WIDTH(NW), .DEPTH(DEPTH)) u_need_ram (
    .clk   (clk),
    .we    (need_we),
    .waddr (waddr),
    .wdata (need_wdata),
    .raddr (raddr),
    .rdata (need_rdata)
  );

  bsa_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_held_ram (
    .clk   (clk),
    .we    (held_we),
    .waddr (waddr),
    .wdata (held_wdata),
    .raddr (raddr),
    .rdata (held_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RESOURCE_TYPES; i++) begin
        avail_r[i] <= '0;
        pend_r[i]  <= '0;
      end
      pend_t_r    <= '0;
      need_vld_r  <= '0;
      held_vld_r  <= '0;
      need_vq_r   <= 1'b0;
      held_vq_r   <= 1'b0;
      r_idx_r     <= '0;
      t_idx_r     <= '0;
      done_r      <= '0;
      progress_r  <= 1'b0;
      eval_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      need_vq_r   <= need_vld_r[raddr];
      held_vq_r   <= held_vld_r[raddr];
      out_valid_r <= cmd.respond;
      if (need_we) begin
        need_vld_r[waddr] <= 1'b1;
      end
      if (held_we) begin
        held_vld_r[waddr] <= 1'b1;
      end
      if (cmd.load_avail && r_ok) begin
        avail_r[rq] <= amt;
      end
      if (cmd.commit_wr) begin
        avail_r[ri] <= avail_cur - p_cur;
      end
      if (cmd.pend_write && r_ok) begin
        pend_r[rq] <= amt;
        pend_t_r   <= req_r.thread;
      end
      if (cmd.pend_clear) begin
        for (int i = 0; i < RESOURCE_TYPES; i++) begin
          pend_r[i] <= '0;
        end
      end
      if (cmd.r_clear) begin
        r_idx_r <= '0;
      end else if (cmd.r_step) begin
        r_idx_r <= r_idx_r + 1'b1;
      end
      if (cmd.scan_init) begin
        eval_r     <= (req_r.operation == OP_REQUEST);
        t_idx_r    <= '0;
        done_r     <= '0;
        progress_r <= 1'b0;
      end else if (cmd.pass_restart) begin
        t_idx_r    <= '0;
        progress_r <= 1'b0;
      end else if (cmd.finish_thread) begin
        t_idx_r    <= t_idx_r + 1'b1;
        done_r     <= done_r + 1'b1;
        progress_r <= 1'b1;
      end else if (cmd.t_step) begin
        t_idx_r <= t_idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_req;
    end
    if (cmd.respond) begin
      out_rsp_r.status <= cmd.status;
      out_rsp_r.safe   <= cmd.safe;
    end
    if (cmd.scan_init) begin
      fin_r <= '0;
      for (int i = 0; i < RESOURCE_TYPES; i++) begin
        work_r[i] <= WW'(avail_r[i]) -
                     (((req_r.operation == OP_REQUEST)) ? WW'(pend_r[i]) : '0);
      end
    end
    if (cmd.finish_thread) begin
      fin_r[t_idx_r[TIW-1:0]] <= 1'b1;
    end
    if (cmd.work_add) begin
      work_r[ri] <= work_sum[WW] ? WORK_MAX : work_sum[WW-1:0];
    end
  end

  assign sts.op        = req_r.operation;
  assign sts.tr_ok     = tr_ok;
  assign sts.last      = req_r.last;
  assign sts.pend_t_ok = pend_t_ok;
  assign sts.r_end     = (r_idx_r >= nr);
  assign sts.t_end     = (t_idx_r >= nt);
  assign sts.fin       = fin_r[t_idx_r[TIW-1:0]];
  assign sts.progress  = progress_r;
  assign sts.all_done  = (done_r == nt);
  assign sts.deny      = (p_s > need_s) || (p_cur > avail_cur);
  assign sts.no_fit    = $signed({{4{need_eff[CW+1]}}, need_eff}) > $signed({1'b0, work_cur});
  assign sts.eval      = eval_r;

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

FILE: rtl/bankers_safe_allocator_top.sv
// bankers safe allocator top level: configuration registers, controller
// and datapath; depends on bsa_pkg, bsa_ctrl, bsa_datapath and the defines header
// A request is taken when start is high and busy is low; its one result appears on
// out_rsp for exactly one cycle with out_valid, and the receiver cannot stall it.
// Load available and load maximum respond from the decode state; load allocation
// first reads the entry, then writes it; a request element without last is stored
// and answered from the decode state. Evaluation runs a limit check over each
// resource, then a safety scan, then a commit over each resource when granted. The
// scan walks threads one at a time through the need and held memories (one read
// each per cycle): each resource of a thread is read and tested against the work
// pool, and when all fit each is read again and added to it; up to nt passes over
// nt threads are made.
`include "bankers_safe_allocator_top_defines.svh"

module bankers_safe_allocator_top
  import bsa_pkg::*;
#(
  parameter int THREAD_SLOTS   = 16,
  parameter int RESOURCE_TYPES = 8,
  parameter int COUNT_BITS     = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  bsa_req_t              in_req,
  output logic                  out_valid,
  output bsa_rsp_t              out_rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [CFG_DATA_W-1:0] threads_r;
  logic [3:0]            resources_r;
  bsa_cmd_t              cmd;
  bsa_sts_t              sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threads_r   <= 5'd16;
      resources_r <= 4'd8;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_THREADS:   threads_r   <= cfg_wdata;
        CFG_RESOURCES: resources_r <= cfg_wdata[3:0];
        default: begin
        end
      endcase
    end
  end

  bsa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  bsa_datapath #(
    .THREAD_SLOTS   (THREAD_SLOTS),
    .RESOURCE_TYPES (RESOURCE_TYPES),
    .COUNT_BITS     (COUNT_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_req        (in_req),
    .cfg_threads   (threads_r),
    .cfg_resources (resources_r),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_rsp       (out_rsp)
  );

  `BSA_ASSERT_NOW(a_result_after_busy, out_valid, $past(busy), "result without a request in work")
  `BSA_ASSERT_NEXT(a_accept_sets_busy, start && !busy, busy, "accepted request did not start")
  `BSA_ASSERT_NOW(a_done_has_result, $fell(busy) && $past(rst_n), out_valid, "request ended without result")

endmodule
